/* hdl/pfd_pkg.sv */
// Shared types and constants of the filtered-derivative PID controller.
package pfd_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU    = 3'd4;

    // Sample period after reset, about 1 ms in Q8.24 seconds.
    localparam logic [CFG_W-1:0] PERIOD_RESET = 32'd16777;

    // Multiplier operands, accumulator and signed product terms.
    localparam int HALF_W = 32;
    localparam int MAC_W  = 2 * HALF_W;
    localparam int ACC_W  = 2 * MAC_W;
    localparam int TERM_W = 64;

    // Product terms are clamped in magnitude at 2^61.
    localparam logic [ACC_W-1:0] TERM_LIMIT = 128'h0000_0000_0000_0000_2000_0000_0000_0000;

    // Divider geometry: 64-bit dividend, denominator 2*tau+T on 34 bits.
    localparam int DIV_NUM_W = 64;
    localparam int DEN_W     = 34;

    // Coefficient magnitude widths: ki*T/2, 2kd/(2tau+T), (2tau-T)/(2tau+T).
    localparam int CI_W = 39;
    localparam int CD_W = 57;
    localparam int CF_W = 31;

    // Binary point of the rounded product.
    typedef enum logic [1:0] {
        SH_16 = 2'd0,
        SH_25 = 2'd1,
        SH_30 = 2'd2
    } shift_sel_t;

    typedef struct packed {
        logic             start;
        logic [MAC_W-1:0] a;
        logic [MAC_W-1:0] b;
        shift_sel_t       shift;
        logic             neg;
    } mac_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TERM_W-1:0] term;
    } mac_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DEN_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

/* hdl/pid_filtered_derivative.sv */
// Top level of the PID controller with trapezoidal integral and filtered derivative.
//
//   Channel   Direction  Handshake                     Contents
//   s_        in         s_tvalid / s_tready           error sample e[k], Q16.16
//   m_        out        m_tvalid / m_tready           control output u[k], Q16.16
//   cfg_wr_   in         cfg_wr_en, no wait            gains, sample period, filter tau
//
// An item takes up to four passes through the shared multiplier (two when 2*tau+T
// is zero), each of four 32x32 partial products plus rounding.
// The first item after reset or after any register write also recomputes the
// coefficients: one multiply and, unless 2*tau+T is zero, two 64-iteration divisions.
// Reset (synchronous, active low) restores the register defaults and clears the state.
// s_tready is high only while idle; a finished result waits in the output register
// and the block returns to idle once the result has been moved into that register.
module pid_filtered_derivative
    import pfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream; s_tdata: error
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
    // Output stream; m_tdata: control
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
    // Register write port
    input  logic                               cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]               cfg_wr_index,
    input  logic [CFG_W-1:0]                   cfg_wr_data
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Saturation bounds of the DATA_WIDTH-bit signed range.
    localparam logic signed [TERM_W-1:0] SAT_MAX =
        {{(TERM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [TERM_W-1:0] SAT_MIN =
        {{(TERM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    // Dividend alignment: 2*|kd| in Q16.16 scaled by 2^24, pole scaled to Q2.30.
    localparam int CD_NUM_SHIFT = 25;
    localparam int CF_NUM_SHIFT = 30;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_CI   = 10'b00_0000_0010,
        ST_CD   = 10'b00_0000_0100,
        ST_CF   = 10'b00_0000_1000,
        ST_UP   = 10'b00_0001_0000,
        ST_UI   = 10'b00_0010_0000,
        ST_SUM  = 10'b00_0100_0000,
        ST_UD1  = 10'b00_1000_0000,
        ST_UD2  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } pfd_state_t;

    function automatic logic [DATA_WIDTH-1:0] sat_dw(input logic signed [TERM_W-1:0] x);
        if (x > SAT_MAX) begin
            return SAT_MAX[DATA_WIDTH-1:0];
        end
        if (x < SAT_MIN) begin
            return SAT_MIN[DATA_WIDTH-1:0];
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    pfd_state_t state_reg, state_next;
    logic       launch_reg;

    logic signed [CFG_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [CFG_W-1:0]        period_reg, tau_reg;
    logic                    coef_stale_reg;

    logic [CI_W-1:0] ci_mag_reg;
    logic            ci_neg_reg;
    logic [CD_W-1:0] cd_mag_reg;
    logic            cd_neg_reg;
    logic [CF_W-1:0] cf_mag_reg;
    logic            cf_neg_reg;

    logic signed [DATA_WIDTH-1:0] e_reg;
    logic signed [DATA_WIDTH-1:0] prev_reg;
    logic signed [DATA_WIDTH-1:0] integ_reg;
    logic signed [DATA_WIDTH-1:0] deriv_reg;
    logic signed [DATA_WIDTH-1:0] ui_reg;
    logic signed [DATA_WIDTH-1:0] ud_reg;
    logic signed [TERM_W-1:0]     td_reg;
    logic signed [TERM_W-1:0]     sum_reg;
    logic [DATA_WIDTH-1:0]        out_reg;
    logic                         m_tvalid_reg;

    mac_req_t mac_req;
    mac_rsp_t mac_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [DEN_W-1:0]      den;
    logic                  den_zero;
    logic signed [DEN_W:0] pole_diff;
    logic [DEN_W:0]        pole_neg;
    logic [DEN_W-1:0]      pole_mag;
    logic [CFG_W-1:0]      kp_mag, ki_mag, kd_mag;
    logic [DATA_WIDTH-1:0] e_mag, deriv_mag;
    logic [DATA_WIDTH:0]   e_sum, e_dif, sum_mag, dif_mag;
    logic signed [TERM_W-1:0] integ_ext, ui_ext, ud_ext;
    logic                  take_in;
    logic                  out_free;

    assign take_in  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Filter denominator 2*tau+T and numerator 2*tau-T.
    assign den       = {1'b0, tau_reg, 1'b0} + {2'b00, period_reg};
    assign den_zero  = (den == '0);
    assign pole_diff = {2'b00, tau_reg, 1'b0} - {3'b000, period_reg};
    assign pole_neg  = -pole_diff;
    assign pole_mag  = pole_diff[DEN_W] ? pole_neg[DEN_W-1:0] : pole_diff[DEN_W-1:0];

    // Operand magnitudes; the signs travel separately to the multiplier.
    assign kp_mag    = kp_reg[CFG_W-1] ? (~kp_reg + 1'b1) : kp_reg;
    assign ki_mag    = ki_reg[CFG_W-1] ? (~ki_reg + 1'b1) : ki_reg;
    assign kd_mag    = kd_reg[CFG_W-1] ? (~kd_reg + 1'b1) : kd_reg;
    assign e_mag     = e_reg[DATA_WIDTH-1] ? (~e_reg + 1'b1) : e_reg;
    assign deriv_mag = deriv_reg[DATA_WIDTH-1] ? (~deriv_reg + 1'b1) : deriv_reg;
    assign e_sum     = {e_reg[DATA_WIDTH-1], e_reg} + {prev_reg[DATA_WIDTH-1], prev_reg};
    assign e_dif     = {e_reg[DATA_WIDTH-1], e_reg} - {prev_reg[DATA_WIDTH-1], prev_reg};
    assign sum_mag   = e_sum[DATA_WIDTH] ? (~e_sum + 1'b1) : e_sum;
    assign dif_mag   = e_dif[DATA_WIDTH] ? (~e_dif + 1'b1) : e_dif;

    assign integ_ext = {{(TERM_W-DATA_WIDTH){integ_reg[DATA_WIDTH-1]}}, integ_reg};
    assign ui_ext    = {{(TERM_W-DATA_WIDTH){ui_reg[DATA_WIDTH-1]}}, ui_reg};
    assign ud_ext    = {{(TERM_W-DATA_WIDTH){ud_reg[DATA_WIDTH-1]}}, ud_reg};

    // Multiplier requests, one product per state.
    always_comb begin
        mac_req.start = 1'b0;
        mac_req.a     = '0;
        mac_req.b     = '0;
        mac_req.shift = SH_16;
        mac_req.neg   = 1'b0;
        case (state_reg)
            ST_CI: begin
                mac_req.start = launch_reg;
                mac_req.a     = MAC_W'(ki_mag);
                mac_req.b     = MAC_W'(period_reg);
                mac_req.shift = SH_25;
            end
            ST_UP: begin
                mac_req.start = launch_reg;
                mac_req.a     = MAC_W'(kp_mag);
                mac_req.b     = MAC_W'(e_mag);
                mac_req.neg   = kp_reg[CFG_W-1] ^ e_reg[DATA_WIDTH-1];
            end
            ST_UI: begin
                mac_req.start = launch_reg;
                mac_req.a     = MAC_W'(ci_mag_reg);
                mac_req.b     = MAC_W'(sum_mag);
                mac_req.neg   = ci_neg_reg ^ e_sum[DATA_WIDTH];
            end
            ST_UD1: begin
                mac_req.start = launch_reg;
                mac_req.a     = MAC_W'(cd_mag_reg);
                mac_req.b     = MAC_W'(dif_mag);
                mac_req.neg   = cd_neg_reg ^ e_dif[DATA_WIDTH];
            end
            ST_UD2: begin
                mac_req.start = launch_reg;
                mac_req.a     = MAC_W'(cf_mag_reg);
                mac_req.b     = MAC_W'(deriv_mag);
                mac_req.shift = SH_30;
                mac_req.neg   = cf_neg_reg ^ deriv_reg[DATA_WIDTH-1];
            end
            default: begin
            end
        endcase
    end

    // Divider requests; half the denominator is added first for rounding.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = den;
        case (state_reg)
            ST_CD: begin
                div_req.start = launch_reg;
                div_req.num   = DIV_NUM_W'({kd_mag, {CD_NUM_SHIFT{1'b0}}})
                              + DIV_NUM_W'(den[DEN_W-1:1]);
            end
            ST_CF: begin
                div_req.start = launch_reg;
                div_req.num   = DIV_NUM_W'({pole_mag, {CF_NUM_SHIFT{1'b0}}})
                              + DIV_NUM_W'(den[DEN_W-1:1]);
            end
            default: begin
            end
        endcase
    end

    pfd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .rsp     (mac_rsp)
    );

    pfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: coefficients when stale, then up to four product terms.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_in) begin
                    state_next = (coef_stale_reg || cfg_wr_en) ? ST_CI : ST_UP;
                end
            end
            ST_CI: begin
                if (mac_rsp.done) begin
                    state_next = den_zero ? ST_UP : ST_CD;
                end
            end
            ST_CD: begin
                if (div_rsp.done) begin
                    state_next = ST_CF;
                end
            end
            ST_CF: begin
                if (div_rsp.done) begin
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (mac_rsp.done) begin
                    state_next = ST_UI;
                end
            end
            ST_UI: begin
                if (mac_rsp.done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = den_zero ? ST_OUT : ST_UD1;
            end
            ST_UD1: begin
                if (mac_rsp.done) begin
                    state_next = ST_UD2;
                end
            end
            ST_UD2: begin
                if (mac_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; a unit is started in the first cycle of each state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= (state_next != state_reg);
        end
    end

    // Configuration registers; any write marks the coefficients stale.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            period_reg     <= PERIOD_RESET;
            tau_reg        <= '0;
            coef_stale_reg <= 1'b1;
        end else begin
            if ((state_reg == ST_CI && mac_rsp.done && den_zero)
                || (state_reg == ST_CF && div_rsp.done)) begin
                coef_stale_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                coef_stale_reg <= 1'b1;
                case (cfg_wr_index)
                    REG_PROP_GAIN:     kp_reg     <= cfg_wr_data;
                    REG_INTEGRAL_GAIN: ki_reg     <= cfg_wr_data;
                    REG_DERIV_GAIN:    kd_reg     <= cfg_wr_data;
                    REG_SAMPLE_PERIOD: period_reg <= cfg_wr_data;
                    REG_FILTER_TAU:    tau_reg    <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Controller state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            integ_reg    <= '0;
            deriv_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                prev_reg     <= e_reg;
                integ_reg    <= ui_reg;
                deriv_reg    <= ud_reg;
            end
        end
    end

    // Datapath registers: coefficients, terms and the output value.
    always_ff @(posedge aclk) begin
        if (take_in) begin
            e_reg <= s_tdata[DATA_WIDTH-1:0];
        end
        case (state_reg)
            ST_CI: begin
                if (mac_rsp.done) begin
                    ci_mag_reg <= mac_rsp.term[CI_W-1:0];
                    ci_neg_reg <= ki_reg[CFG_W-1];
                end
            end
            ST_CD: begin
                if (div_rsp.done) begin
                    cd_mag_reg <= div_rsp.quot[CD_W-1:0];
                    cd_neg_reg <= kd_reg[CFG_W-1];
                end
            end
            ST_CF: begin
                if (div_rsp.done) begin
                    cf_mag_reg <= div_rsp.quot[CF_W-1:0];
                    cf_neg_reg <= pole_diff[DEN_W];
                end
            end
            ST_UP: begin
                if (mac_rsp.done) begin
                    sum_reg <= mac_rsp.term;
                end
            end
            ST_UI: begin
                if (mac_rsp.done) begin
                    ui_reg <= sat_dw(mac_rsp.term + integ_ext);
                end
            end
            ST_SUM: begin
                sum_reg <= sum_reg + ui_ext;
                if (den_zero) begin
                    ud_reg <= '0;
                end
            end
            ST_UD1: begin
                if (mac_rsp.done) begin
                    td_reg <= mac_rsp.term;
                end
            end
            ST_UD2: begin
                if (mac_rsp.done) begin
                    ud_reg <= sat_dw(td_reg + mac_rsp.term);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_reg <= sat_dw(sum_reg + ud_ext);
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_reg);

endmodule

/* hdl/pfd_mac.sv */
// Shared multiply unit: 64x64 magnitude product from 32x32 partial products, rounded and clamped.
module pfd_mac
    import pfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mac_req_t req,
    output mac_rsp_t rsp
);

    logic [MAC_W-1:0]         a_reg;
    logic [MAC_W-1:0]         b_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [MAC_W-1:0]         pp_reg;
    logic [1:0]               lane_reg;
    logic                     pp_vld_reg;
    logic [2:0]               step_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic                     neg_reg;
    shift_sel_t               shift_reg;
    logic signed [TERM_W-1:0] term_reg;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [ACC_W-1:0]  pp_aligned;
    logic [ACC_W-1:0]  round_in;
    logic [ACC_W-1:0]  q_full;
    logic [TERM_W-1:0] q_mag;

    // Step bit 0 picks the half of a, step bit 1 the half of b.
    assign a_half = step_reg[0] ? a_reg[MAC_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_half = step_reg[1] ? b_reg[MAC_W-1:HALF_W] : b_reg[HALF_W-1:0];

    // Align the registered partial product to its weight.
    always_comb begin
        case (lane_reg)
            2'd0:    pp_aligned = {{MAC_W{1'b0}}, pp_reg};
            2'd1:    pp_aligned = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            2'd2:    pp_aligned = {pp_reg, {MAC_W{1'b0}}};
            default: pp_aligned = '0;
        endcase
    end

    // The accumulator starts at half an output LSB so truncation rounds to nearest.
    always_comb begin
        case (req.shift)
            SH_16:   round_in = ACC_W'(1) << 15;
            SH_25:   round_in = ACC_W'(1) << 24;
            SH_30:   round_in = ACC_W'(1) << 29;
            default: round_in = '0;
        endcase
    end

    // Drop the fraction bits, clamp the magnitude and apply the sign.
    always_comb begin
        case (shift_reg)
            SH_16:   q_full = acc_reg >> 16;
            SH_25:   q_full = acc_reg >> 25;
            SH_30:   q_full = acc_reg >> 30;
            default: q_full = acc_reg;
        endcase
        q_mag = (q_full > TERM_LIMIT) ? TERM_LIMIT[TERM_W-1:0] : q_full[TERM_W-1:0];
    end

    // Step sequencer: four multiplies, one trailing add, then the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg   <= 1'b1;
                step_reg   <= '0;
                pp_vld_reg <= 1'b0;
            end else if (busy_reg) begin
                step_reg   <= step_reg + 3'd1;
                pp_vld_reg <= (step_reg < 3'd4);
                if (step_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand capture, multiply stage and accumulate stage.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg     <= req.a;
            b_reg     <= req.b;
            shift_reg <= req.shift;
            neg_reg   <= req.neg;
            acc_reg   <= round_in;
        end else if (busy_reg) begin
            pp_reg   <= a_half * b_half;
            lane_reg <= {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + pp_aligned;
            end
            if (step_reg == 3'd5) begin
                term_reg <= neg_reg ? (~q_mag + 1'b1) : q_mag;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.term = term_reg;

endmodule

/* hdl/pfd_div.sv */
// Restoring divider for the derivative coefficients, one quotient bit per cycle.
module pfd_div
    import pfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // Shift in the next dividend bit and try to subtract the denominator.
    assign trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = (trial >= {1'b0, den_reg});
    assign rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    // Iteration counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend register fills with quotient bits from the bottom.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

/* hdl/pfd_checker.sv */
// Port-level checks of the PID controller and the bind that attaches them.
module pfd_checker #(
    parameter int DATA_WIDTH = 32
)
(
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata
);

    // The block works on one sample at a time.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample was still in progress");

    // A new result is posted in the same cycle the sequencer returns to idle.
    a_idle_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted while the sequencer was still busy");

    // A result is only ever posted at the end of a busy period.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample being processed");

    // A stalled result keeps its value until the transfer completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or was dropped");

    // Reset empties the output and leaves the block ready.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle after reset");

endmodule

bind pid_filtered_derivative pfd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// Self-checking testbench for the filtered-derivative PID controller.
`timescale 1ns / 100ps

module testbench;
    import pfd_pkg::*;

    localparam int W = 32;
    localparam int GROUPS = 7;
    localparam int ITEMS_PER_GROUP = 100;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_RESULTS = 480;

    localparam longint WORD_MAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (W - 1));
    localparam logic [127:0] PRODUCT_CAP = 128'd1 << 61;

    // Predicts the control output from accepted error samples and holds the
    // outputs still to come, oldest first.
    class control_scoreboard;
        longint kp, ki, kd;
        logic [63:0] period, tau;
        longint last_error, integ, deriv;
        logic [W-1:0] expected_q[$];
        int mismatches;

        function new();
            kp = 0;
            ki = 0;
            kd = 0;
            period = PERIOD_RESET;
            tau = 0;
            last_error = 0;
            integ = 0;
            deriv = 0;
            mismatches = 0;
        endfunction

        function logic [63:0] magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function longint clamp_word(longint x);
            if (x > WORD_MAX)
                return WORD_MAX;
            if (x < WORD_MIN)
                return WORD_MIN;
            return x;
        endfunction

        // Exact product scaled down by 2^sh, rounded half away from zero and
        // clamped in magnitude before it is summed.
        function longint round_product(longint a, longint b, int sh);
            logic [127:0] p;
            logic [127:0] q;
            p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
            q = (p + (128'd1 << (sh - 1))) >> sh;
            if (q > PRODUCT_CAP)
                q = PRODUCT_CAP;
            return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function longint rounded_ratio(logic [63:0] num, bit neg, logic [63:0] den);
            logic [63:0] q;
            q = (num + (den >> 1)) / den;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PROP_GAIN:     kp = $signed(value);
                REG_INTEGRAL_GAIN: ki = $signed(value);
                REG_DERIV_GAIN:    kd = $signed(value);
                REG_SAMPLE_PERIOD: period = value;
                REG_FILTER_TAU:    tau = value;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [W-1:0] err_in);
            longint e, up, ci, ui, ud, u, diff, cd, cf;
            logic [63:0] ki_t, den;
            e = $signed(err_in);
            up = round_product(kp, e, 16);

            // Trapezoidal integral with coefficient ki*T/2.
            ki_t = magnitude(ki) * period;
            ci = longint'((ki_t + 64'd16777216) >> 25);
            if (ki < 0)
                ci = -ci;
            ui = clamp_word(round_product(ci, e + last_error, 16) + integ);

            // Filtered derivative; a zero denominator forces the term to zero.
            den = (tau << 1) + period;
            if (den == 0) begin
                ud = 0;
            end else begin
                diff = longint'(tau << 1) - longint'(period);
                cd = rounded_ratio(magnitude(kd) << 25, kd < 0, den);
                cf = rounded_ratio(magnitude(diff) << 30, diff < 0, den);
                ud = clamp_word(round_product(cd, e - last_error, 16)
                                + round_product(cf, deriv, 30));
            end

            u = clamp_word(up + ui + ud);
            last_error = e;
            integ = ui;
            deriv = ud;
            expected_q.push_back(u[W-1:0]);
        endfunction

        function void check_control(logic [W-1:0] got);
            logic [W-1:0] want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: control %h arrived with no sample outstanding", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: control expected %h, got %h", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    control_scoreboard board;
    int send_idle_pct = 22;
    int recv_idle_pct = 73;
    int results_seen = 0;
    int quiet_cycles = 0;

    pid_filtered_derivative #(
        .DATA_WIDTH(W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offers one error sample and returns at the edge of its transfer.
    // The valid stays high afterwards so back-to-back samples need no gap.
    task automatic send_sample(input logic [W-1:0] err_in);
        bit ready_seen;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= err_in;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        board.note_sample(err_in);
    endtask

    // Drives one register write; cfg_done ends a batch of writes.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.write_reg(idx, value);
    endtask

    task automatic cfg_done();
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_gains(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] i,
                             input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] t,
                             input logic [CFG_W-1:0] f);
        cfg_write(REG_PROP_GAIN, p);
        cfg_write(REG_INTEGRAL_GAIN, i);
        cfg_write(REG_DERIV_GAIN, d);
        cfg_write(REG_SAMPLE_PERIOD, t);
        cfg_write(REG_FILTER_TAU, f);
        cfg_done();
    endtask

    // Stops offering and waits until every predicted output has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [W-1:0] random_error(logic [W-1:0] previous);
        logic [W-1:0] v;
        v = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1))
            v = -v;
        case ($urandom_range(0, 9))
            0, 1: return previous;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4, 5: return $urandom;
            default: return v;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        logic [CFG_W-1:0] v;
        v = $urandom_range(0, 10 << 16);
        if ($urandom_range(0, 1))
            v = -v;
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom;
            default: return v;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hffff_ffff;
            2: return PERIOD_RESET;
            3: return $urandom;
            default: return $urandom_range(1, 1 << 24);
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold-off that lets the
    // block fill up while samples keep being offered.
    initial begin
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= HOLD_AFTER_RESULTS) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Output monitor and watchdog. Inputs only change at rising edges, so the
    // values seen at a falling edge are those of the following transfer edge.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_control(m_tdata);
                results_seen++;
            end
            if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("pid_filtered_derivative test failed");
        $finish;
    end

    // Main sequence: reset, directed samples, then randomized phases.
    initial begin
        logic [W-1:0] last_err;
        board = new();
        last_err = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset gains are zero, so any error gives zero output.
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);

        // Unity proportional gain alone.
        wait_drained();
        cfg_write(REG_PROP_GAIN, 32'h0001_0000);
        cfg_done();
        send_sample(32'h0000_0001);
        send_sample(32'hffff_ffff);
        send_sample(32'h0000_8000);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);

        // Realistic gains with a filtered derivative.
        wait_drained();
        set_gains(32'h0001_0000, 32'h0064_0000, 32'h0001_0000, PERIOD_RESET, 32'd83885);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_0000);
        send_sample(32'hfffe_0000);

        // Largest gains and times: all terms saturate.
        wait_drained();
        set_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        send_sample(32'h7fff_ffff);
        send_sample(32'h0000_0000);

        // Most negative kp and ki, largest kd, no filter: the derivative pole goes negative.
        wait_drained();
        set_gains(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7fff_ffff);
        send_sample(32'h0000_0001);

        // Zero period and zero filter constant leave no derivative; writes to
        // indexes past the register list must change nothing.
        wait_drained();
        set_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        for (int r = REG_FILTER_TAU + 1; r < (1 << CFG_IDX_W); r++)
            cfg_write(r, 32'hffff_ffff);
        cfg_done();
        send_sample(32'h0010_0000);
        send_sample(32'hfff0_0000);

        // Random phases, each with its own register setting; the idle pattern changes between groups of phases.
        for (int g = 0; g < GROUPS; g++) begin
            wait_drained();
            if (g < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 73;
            end else if (g < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_gains(pick_gain(), pick_gain(), pick_gain(), pick_time(), pick_time());
            for (int i = 0; i < ITEMS_PER_GROUP; i++) begin
                last_err = random_error(last_err);
                send_sample(last_err);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("pid_filtered_derivative test passed");
        else
            $display("pid_filtered_derivative test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/pfd_pkg.sv
hdl/pfd_mac.sv
hdl/pfd_div.sv
hdl/pid_filtered_derivative.sv
hdl/pfd_checker.sv
tb/testbench.sv
